// File: rtl/pfms_pkg.sv
// Package: constants, types and command/status structs for the pinned FIFO message store.
package pfms_pkg;
  localparam int unsigned EntryCount = 32;
  localparam int unsigned SlotW = $clog2(EntryCount + 1);
  localparam int unsigned IdxW = $clog2(EntryCount);
  localparam logic [SlotW-1:0] NilSlot = SlotW'(EntryCount);
  localparam int unsigned RecW = 16 + 32 + 8 + 32 + 32 + 8 + 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_LOCK = 2'd1,
    OP_CUR_NEWEST = 2'd2,
    OP_CUR_OLDER = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_ALL_PINNED = 2'd1,
    ST_NO_ENTRY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_FREE_SCAN,
    S_WALK_RD,
    S_WALK_CHK,
    S_UNLINK,
    S_LINK,
    S_RESP_RD,
    S_RESP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic ptr_zero;
    logic ptr_load_oldest;
    logic ptr_load_newest;
    logic ptr_load_cursor;
    logic ptr_inc;
    logic ptr_follow_next;
    logic ptr_follow_prev;
    logic link_rd;
    logic unlink;
    logic write_new;
    logic toggle_lock;
    logic set_cursor_ptr;
    logic set_cursor_nil;
    logic load_ok;
    logic load_fail;
    logic load_nomatch;
    logic out_valid_set;
    logic rank_inc;
  } cmd_t;

  typedef struct packed {
    opcode_e    op;
    logic       full;
    logic       ptr_nil;
    logic       ptr_free;
    logic       ptr_unpinned;
    logic       rank_match;
    logic       cursor_nil;
    logic       out_taken;
  } stat_t;
endpackage

// File: rtl/pfms_ram.sv
// Generic single-port RAM with registered read.
module pfms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/pfms_datapath.sv
// Datapath: record memory, link tables, flags, pointers and output register.
module pfms_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfms_pkg::cmd_t       cmd_i,
  output pfms_pkg::stat_t      stat_o,
  input  logic [1:0]           opcode_i,
  input  logic [pfms_pkg::RecW-1:0] rec_i,
  input  logic                 chosen_i,
  input  logic                 locked_in_i,
  input  logic [7:0]           row_rank_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [7:0]           slot_o,
  output logic [pfms_pkg::RecW-1:0] rec_o,
  output logic                 out_chosen_o,
  output logic                 out_locked_o
);
  localparam int unsigned SW = pfms_pkg::SlotW;
  localparam int unsigned IW = pfms_pkg::IdxW;
  localparam int unsigned N = pfms_pkg::EntryCount;

  logic [1:0] op_q;
  logic [pfms_pkg::RecW-1:0] rec_q;
  logic [1:0] flags_in_q;
  logic [7:0] rank_q;
  logic [SW-1:0] ptr_q, ptr_d;
  logic [8:0] cnt_q;
  logic [SW-1:0] oldest_q, newest_q, cursor_q;
  logic [SW:0] count_q;
  logic [N-1:0] valid_q;
  logic [1:0] flags_q [N];
  logic [SW-1:0] prev_q [N];
  logic [SW-1:0] next_q [N];
  logic [SW-1:0] hold_prev_q, hold_next_q;
  logic [IW-1:0] pidx;
  logic [pfms_pkg::RecW-1:0] ram_rd;
  logic out_valid_q;
  logic [1:0] status_q;
  logic [7:0] slot_q;
  logic [1:0] oflags_q;
  logic ok_q;

  assign pidx = ptr_q[IW-1:0];

  pfms_ram #(.Width(pfms_pkg::RecW), .Depth(N)) u_rec_ram (
    .clk_i,
    .we_i   (cmd_i.write_new),
    .addr_i (pidx),
    .wdata_i(rec_q),
    .rdata_o(ram_rd)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_zero) ptr_d = '0;
    else if (cmd_i.ptr_load_oldest) ptr_d = oldest_q;
    else if (cmd_i.ptr_load_newest) ptr_d = newest_q;
    else if (cmd_i.ptr_load_cursor) ptr_d = cursor_q;
    else if (cmd_i.ptr_inc) ptr_d = ptr_q + SW'(1);
    else if (cmd_i.ptr_follow_next) ptr_d = next_q[pidx];
    else if (cmd_i.ptr_follow_prev) ptr_d = prev_q[pidx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      rec_q <= rec_i;
      flags_in_q <= {locked_in_i, chosen_i};
      rank_q <= row_rank_i;
    end
    if (cmd_i.link_rd) begin
      hold_prev_q <= prev_q[pidx];
      hold_next_q <= next_q[pidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= pfms_pkg::NilSlot;
      cnt_q <= '0;
      oldest_q <= pfms_pkg::NilSlot;
      newest_q <= pfms_pkg::NilSlot;
      cursor_q <= pfms_pkg::NilSlot;
      count_q <= '0;
      valid_q <= '0;
      for (int i = 0; i < N; i++) begin
        flags_q[i] <= '0;
        prev_q[i] <= pfms_pkg::NilSlot;
        next_q[i] <= pfms_pkg::NilSlot;
      end
      out_valid_q <= 1'b0;
      status_q <= '0;
      slot_q <= '0;
      oflags_q <= '0;
      ok_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.capture) cnt_q <= '0;
      else if (cmd_i.rank_inc) cnt_q <= cnt_q + 9'd1;
      if (cmd_i.unlink) begin
        if (hold_prev_q != pfms_pkg::NilSlot) next_q[hold_prev_q[IW-1:0]] <= hold_next_q;
        else oldest_q <= hold_next_q;
        if (hold_next_q != pfms_pkg::NilSlot) prev_q[hold_next_q[IW-1:0]] <= hold_prev_q;
        else newest_q <= hold_prev_q;
      end
      if (cmd_i.write_new) begin
        flags_q[pidx] <= flags_in_q;
        valid_q[pidx] <= 1'b1;
        next_q[pidx] <= pfms_pkg::NilSlot;
        prev_q[pidx] <= newest_q;
        if (newest_q != pfms_pkg::NilSlot) next_q[newest_q[IW-1:0]] <= ptr_q;
        else oldest_q <= ptr_q;
        newest_q <= ptr_q;
        if (count_q < (SW+1)'(N)) count_q <= count_q + (SW+1)'(1);
      end
      if (cmd_i.toggle_lock) flags_q[pidx] <= flags_q[pidx] ^ 2'b10;
      if (cmd_i.set_cursor_ptr) cursor_q <= ptr_q;
      if (cmd_i.set_cursor_nil) cursor_q <= pfms_pkg::NilSlot;
      if (cmd_i.load_ok) begin
        status_q <= pfms_pkg::ST_DONE;
        slot_q <= 8'(ptr_q);
        oflags_q <= flags_q[pidx];
        ok_q <= 1'b1;
      end
      if (cmd_i.load_fail || cmd_i.load_nomatch) begin
        status_q <= cmd_i.load_fail ? pfms_pkg::ST_ALL_PINNED : pfms_pkg::ST_NO_ENTRY;
        slot_q <= '0;
        oflags_q <= '0;
        ok_q <= 1'b0;
      end
      if (cmd_i.out_valid_set) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  logic [pfms_pkg::RecW-1:0] out_rec_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_valid_set) out_rec_q <= ok_q ? ram_rd : '0;
  end

  assign stat_o.op = pfms_pkg::opcode_e'(op_q);
  assign stat_o.full = (count_q == (SW+1)'(N));
  assign stat_o.ptr_nil = (ptr_q == pfms_pkg::NilSlot);
  assign stat_o.ptr_free = !valid_q[pidx];
  assign stat_o.ptr_unpinned = (flags_q[pidx] == 2'b00);
  assign stat_o.rank_match = (cnt_q == {1'b0, rank_q});
  assign stat_o.cursor_nil = (cursor_q == pfms_pkg::NilSlot);
  assign stat_o.out_taken = out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
  assign rec_o = out_rec_q;
  assign out_chosen_o = oflags_q[0];
  assign out_locked_o = oflags_q[1];

  property p_count_matches;
    @(posedge clk_i) disable iff (!rst_ni)
      (count_q == '0) |-> (newest_q == pfms_pkg::NilSlot);
  endproperty
  a_count_matches: assert property (p_count_matches) else $error("empty store with newest");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (SW+1)'(N)) else $error("count overflow");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != pfms_pkg::ST_DONE) |-> (slot_q == '0 && oflags_q == '0))
    else $error("failed result carries data");
endmodule

// File: rtl/pfms_ctrl.sv
// Controller state machine sequencing adds, lock walks and cursor moves.
module pfms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pfms_pkg::stat_t stat_i,
  output pfms_pkg::cmd_t  cmd_o
);
  pfms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pfms_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pfms_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = pfms_pkg::S_DECIDE;
        end
      end
      pfms_pkg::S_DECIDE: begin
        unique case (stat_i.op)
          pfms_pkg::OP_ADD: begin
            if (stat_i.full) begin
              cmd_o.ptr_load_oldest = 1'b1;
              state_d = pfms_pkg::S_WALK_CHK;
            end else begin
              cmd_o.ptr_zero = 1'b1;
              state_d = pfms_pkg::S_FREE_SCAN;
            end
          end
          pfms_pkg::OP_LOCK: begin
            cmd_o.ptr_load_newest = 1'b1;
            state_d = pfms_pkg::S_WALK_RD;
          end
          pfms_pkg::OP_CUR_NEWEST: begin
            cmd_o.ptr_load_newest = 1'b1;
            state_d = pfms_pkg::S_WALK_RD;
          end
          default: begin
            cmd_o.ptr_load_cursor = 1'b1;
            state_d = pfms_pkg::S_WALK_RD;
          end
        endcase
      end
      pfms_pkg::S_FREE_SCAN: begin
        if (stat_i.ptr_free) begin
          state_d = pfms_pkg::S_LINK;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      pfms_pkg::S_WALK_CHK: begin
        if (stat_i.ptr_nil) begin
          cmd_o.load_fail = 1'b1;
          state_d = pfms_pkg::S_RESP;
        end else if (stat_i.ptr_unpinned) begin
          cmd_o.link_rd = 1'b1;
          state_d = pfms_pkg::S_UNLINK;
        end else begin
          cmd_o.ptr_follow_next = 1'b1;
        end
      end
      pfms_pkg::S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = pfms_pkg::S_LINK;
      end
      pfms_pkg::S_LINK: begin
        cmd_o.write_new = 1'b1;
        state_d = pfms_pkg::S_RESP_RD;
      end
      pfms_pkg::S_WALK_RD: begin
        unique case (stat_i.op)
          pfms_pkg::OP_LOCK: begin
            if (stat_i.ptr_nil) begin
              cmd_o.load_nomatch = 1'b1;
              state_d = pfms_pkg::S_RESP;
            end else if (stat_i.rank_match) begin
              cmd_o.toggle_lock = 1'b1;
              state_d = pfms_pkg::S_RESP_RD;
            end else begin
              cmd_o.ptr_follow_prev = 1'b1;
              cmd_o.rank_inc = 1'b1;
            end
          end
          pfms_pkg::OP_CUR_NEWEST: begin
            if (stat_i.ptr_nil) begin
              cmd_o.load_nomatch = 1'b1;
              state_d = pfms_pkg::S_RESP;
            end else begin
              cmd_o.set_cursor_ptr = 1'b1;
              state_d = pfms_pkg::S_RESP_RD;
            end
          end
          default: begin
            if (stat_i.ptr_nil) begin
              cmd_o.set_cursor_nil = 1'b1;
              cmd_o.load_nomatch = 1'b1;
              state_d = pfms_pkg::S_RESP;
            end else begin
              cmd_o.ptr_follow_prev = 1'b1;
              state_d = pfms_pkg::S_RESP_RD;
            end
          end
        endcase
      end
      pfms_pkg::S_RESP_RD: begin
        if (stat_i.op == pfms_pkg::OP_CUR_OLDER) begin
          if (stat_i.ptr_nil) begin
            cmd_o.set_cursor_nil = 1'b1;
            cmd_o.load_nomatch = 1'b1;
          end else begin
            cmd_o.set_cursor_ptr = 1'b1;
            cmd_o.load_ok = 1'b1;
          end
        end else begin
          cmd_o.load_ok = 1'b1;
        end
        state_d = pfms_pkg::S_RESP;
      end
      pfms_pkg::S_RESP: begin
        cmd_o.out_valid_set = 1'b1;
        state_d = pfms_pkg::S_OUT;
      end
      pfms_pkg::S_OUT: begin
        if (stat_i.out_taken) state_d = pfms_pkg::S_IDLE;
      end
      default: state_d = pfms_pkg::S_IDLE;
    endcase
  end

  a_one_link_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.write_new && cmd_o.unlink)) else $error("link conflict");
  a_unlink_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.unlink |=> cmd_o.write_new) else $error("unlink without write");
  a_resp_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_valid_set |=> (state_q == pfms_pkg::S_OUT)) else $error("result lost");
endmodule

// File: rtl/pinned_fifo_message_store.sv
// Top level of the pinned FIFO message store.
// An add takes the first free slot, scanning upward from slot 0; when the store is full it
// walks from the oldest entry past pinned ones, reuses the first unpinned entry, or fails.
// A lock walks from the newest entry to older ones until the rank matches or none is left.
// One transaction at a time; the next input is taken only after the result is accepted.
// Reset clears valid bits, flags, links and pointers at once; record memory is not cleared.
module pinned_fifo_message_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] msg_id_i,
  input  logic [31:0] content_handle_i,
  input  logic [7:0]  channel_i,
  input  logic [31:0] msg_date_i,
  input  logic [31:0] msg_time_i,
  input  logic [7:0]  msg_type_i,
  input  logic        chosen_i,
  input  logic        locked_in_i,
  input  logic [31:0] code_format_i,
  input  logic [7:0]  row_rank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_o,
  output logic [15:0] out_msg_id_o,
  output logic [31:0] out_content_o,
  output logic [7:0]  out_channel_o,
  output logic [31:0] out_date_o,
  output logic [31:0] out_time_o,
  output logic [7:0]  out_type_o,
  output logic        out_chosen_o,
  output logic        out_locked_o,
  output logic [31:0] out_format_o
);
  pfms_pkg::cmd_t cmd;
  pfms_pkg::stat_t stat;
  logic [pfms_pkg::RecW-1:0] rec_in, rec_out;

  assign rec_in = {msg_id_i, content_handle_i, channel_i, msg_date_i, msg_time_i,
                   msg_type_i, code_format_i};
  assign {out_msg_id_o, out_content_o, out_channel_o, out_date_o, out_time_o,
          out_type_o, out_format_o} = rec_out;

  pfms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  pfms_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .opcode_i, .rec_i(rec_in), .chosen_i, .locked_in_i, .row_rank_i,
    .out_ready_i, .out_valid_o, .status_o, .slot_o,
    .rec_o(rec_out), .out_chosen_o, .out_locked_o
  );
endmodule
